/* design/nws_pkg.sv */
// ----------------------------------------------------------------------------
// Neuron weighted sum package
// Shared constants, configuration and control types, and the logistic lookup
// table that is built during elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package nws_pkg;

   localparam int MAX_INPUTS    = 64;
   localparam int TABLE_ENTRIES = 256;
   localparam int FRACTION_BITS = 12;

   localparam int POS_W       = $clog2(MAX_INPUTS);
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 7;
   localparam int GAMMA_W     = 15;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 40;
   localparam int IDX_W       = $clog2(TABLE_ENTRIES);
   localparam int IDX_SHIFT   = 2 * FRACTION_BITS + 4 - IDX_W;

   localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SIGMOID = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BIPOLAR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TANH    = 2'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVATION_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INPUT_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_VALUE      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_GAIN      = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   activation_mode;
      logic [COUNT_W-1:0]  input_count;
      logic [SAMPLE_W-1:0] bias_value;
      logic [GAMMA_W-1:0]  gamma_gain;
   } cfg_type;

   typedef struct packed {
      logic write_weight;
      logic read_weight;
      logic mac;
      logic scale;
      logic arg;
      logic index;
      logic lookup;
      logic square;
      logic reduce;
      logic gain;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_element;
   } ctrl_status_type;

   typedef logic [TABLE_ENTRIES-1:0][SAMPLE_W-1:0] table_type;

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Logistic of k*16/TABLE_ENTRIES for k >= 0, from a Q30 exponential series.
   function automatic logic [63:0] logistic_pos(input logic [63:0] k);
      logic [63:0] term;
      logic [63:0] ex;
      logic [63:0] en;
      logic [63:0] d;
      term = 64'd1 << 30;
      ex   = term;
      for (int j = 1; j <= 24; j++) begin
         term = udiv64(term * (64'd2 * k), 64'(TABLE_ENTRIES * j));
         ex   = ex + term;
      end
      en = udiv64((64'd1 << 60) + (ex >> 1), ex);
      for (int j = 0; j < 3; j++) begin
         en = (en * en + (64'd1 << 29)) >> 30;
      end
      d = (64'd1 << 30) + en;
      return udiv64((64'd1 << (FRACTION_BITS + 30)) + (d >> 1), d);
   endfunction

   function automatic table_type build_logistic_table();
      table_type tab;
      tab = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (i >= TABLE_ENTRIES / 2) begin
            tab[i] = SAMPLE_W'(logistic_pos(64'(i - TABLE_ENTRIES / 2)));
         end else begin
            tab[i] = SAMPLE_W'((64'd1 << FRACTION_BITS)
                               - logistic_pos(64'(TABLE_ENTRIES / 2 - i)));
         end
      end
      return tab;
   endfunction

   localparam table_type LOGISTIC_TABLE = build_logistic_table();

endpackage

`default_nettype wire

/* design/nws_ctrl.sv */
// ----------------------------------------------------------------------------
// Neuron weighted sum controller
// Sequences weight loads, multiply-accumulate steps and the activation steps,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module nws_ctrl
   import nws_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_cmd,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_MAC    = 10'b0000000010,
      ST_SCALE  = 10'b0000000100,
      ST_ARG    = 10'b0000001000,
      ST_INDEX  = 10'b0000010000,
      ST_LOOKUP = 10'b0000100000,
      ST_SQUARE = 10'b0001000000,
      ST_REDUCE = 10'b0010000000,
      ST_GAIN   = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_DATA) begin
                  cmd.read_weight = 1'b1;
                  state_in        = ST_MAC;
               end else begin
                  cmd.write_weight = 1'b1;
               end
            end
         end
         ST_MAC: begin
            cmd.mac  = 1'b1;
            state_in = status.last_element ? ST_SCALE : ST_IDLE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ARG;
         end
         ST_ARG: begin
            cmd.arg  = 1'b1;
            state_in = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.index = 1'b1;
            state_in  = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_result_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("Result transaction appeared without a finish step.");

   a_mac_after_data : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> $past(cmd.read_weight))
      else $error("Accumulate step without an accepted data transaction.");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.load_out)
      else $error("Pending result transaction overwritten.");

   a_activation_on_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> $past(state_ff == ST_MAC && status.last_element))
      else $error("Activation started on an element that is not the last.");

endmodule

`default_nettype wire

/* design/nws_datapath.sv */
// ----------------------------------------------------------------------------
// Neuron weighted sum datapath
// Weight store, multiply-accumulate, table based activation, derivative
// arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nws_datapath
   import nws_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  ctrl_cmd_type               cmd,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output ctrl_status_type            status,
   output logic signed [SAMPLE_W-1:0] rsp_activation_out,
   output logic signed [SAMPLE_W-1:0] rsp_derivative_out
);

   localparam int PROD_W  = 2 * SAMPLE_W;
   localparam int GPROD_W = SUM_W + GAMMA_W + 1;
   localparam int ARG_W   = GPROD_W + 1 - FRACTION_BITS;
   localparam int IDXT_W  = ARG_W + 1 - IDX_SHIFT;
   localparam int LIN_W   = SUM_W + 1 - FRACTION_BITS;
   localparam int SQ_W    = 2 * SAMPLE_W + 1;
   localparam int RED_W   = SQ_W + 1 - FRACTION_BITS;
   localparam int DV_W    = RED_W + 1;
   localparam int GQ_W    = DV_W + GAMMA_W + 1;
   localparam int FIN_W   = GQ_W - FRACTION_BITS;
   localparam int SAT_W   = 32;
   localparam int HALF_F  = 1 << (FRACTION_BITS - 1);
   localparam int HALF_G  = 1 << FRACTION_BITS;
   localparam int HALF_I  = 1 << (IDX_SHIFT - 1);

   localparam logic signed [SAMPLE_W-1:0] ONE_Q    = SAMPLE_W'(1 << FRACTION_BITS);
   localparam logic signed [IDXT_W-1:0]   IDX_LOW  = IDXT_W'(-(TABLE_ENTRIES / 2));
   localparam logic signed [IDXT_W-1:0]   IDX_HIGH = IDXT_W'(TABLE_ENTRIES / 2 - 1);
   localparam logic signed [SAT_W-1:0]    SAT_MAX  = SAT_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [SAT_W-1:0]    SAT_MIN  = SAT_W'(-(2 ** (SAMPLE_W - 1)));

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAMPLE_W'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         r = SAMPLE_W'(SAT_MIN);
      end else begin
         r = SAMPLE_W'(v);
      end
      return r;
   endfunction

   logic signed [SAMPLE_W-1:0] weight_store_ff [MAX_INPUTS];
   logic signed [SAMPLE_W-1:0] weight_rd_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       first_ff;
   logic                       last_ff;
   logic                       last_in;

   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [GPROD_W-1:0]  gprod_ff, gprod_in;
   logic signed [ARG_W-1:0]    arg_ff, arg_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic signed [SQ_W-1:0]     sq_ff, sq_in;
   logic signed [DV_W-1:0]     dv_ff, dv_in;
   logic signed [GQ_W-1:0]     gq_ff, gq_in;
   logic signed [SAMPLE_W-1:0] act_ff;
   logic signed [SAMPLE_W-1:0] deriv_ff, deriv_in;

   logic signed [PROD_W-1:0]   product;
   logic signed [SUM_W-1:0]    bias_sum;
   logic signed [GAMMA_W:0]    gamma_s;
   logic [GPROD_W:0]           gprod_rnd;
   logic [ARG_W:0]             arg_rnd;
   logic signed [IDXT_W-1:0]   idx_t;
   logic [SAMPLE_W-1:0]        tab;
   logic [SUM_W:0]             lin_rnd;
   logic signed [LIN_W-1:0]    lin;
   logic signed [SAMPLE_W:0]   factor;
   logic [SQ_W:0]              sq_rnd;
   logic signed [RED_W-1:0]    red;
   logic [GQ_W:0]              gq_rnd;
   logic signed [FIN_W-1:0]    fin;

   always_ff @(posedge clock) begin
      if (cmd.write_weight) begin
         weight_store_ff[req_position] <= req_sample;
      end
      if (cmd.read_weight) begin
         weight_rd_ff <= weight_store_ff[req_position];
      end
   end

   assign last_in = ({1'b0, req_position} == (cfg.input_count - COUNT_W'(1)));

   assign product  = PROD_W'(sample_ff) * PROD_W'(weight_rd_ff);
   assign bias_sum = SUM_W'($signed(cfg.bias_value)) <<< FRACTION_BITS;
   assign sum_in   = (first_ff ? bias_sum : sum_ff) + SUM_W'(product);

   assign gamma_s  = $signed({1'b0, cfg.gamma_gain});
   assign gprod_in = GPROD_W'(gamma_s) * GPROD_W'(sum_ff);

   assign gprod_rnd = (GPROD_W + 1)'(gprod_ff) + (GPROD_W + 1)'(HALF_F);

   always_comb begin
      case (cfg.activation_mode)
         MODE_TANH:    arg_in = ARG_W'(sum_ff) <<< 1;
         MODE_BIPOLAR: arg_in = $signed(gprod_rnd[GPROD_W:FRACTION_BITS]);
         default:      arg_in = ARG_W'(sum_ff);
      endcase
   end

   assign arg_rnd = (ARG_W + 1)'(arg_ff) + (ARG_W + 1)'(HALF_I);
   assign idx_t   = $signed(arg_rnd[ARG_W:IDX_SHIFT]);

   always_comb begin
      if (idx_t < IDX_LOW) begin
         idx_in = '0;
      end else if (idx_t > IDX_HIGH) begin
         idx_in = '1;
      end else begin
         idx_in = {~idx_t[IDX_W-1], idx_t[IDX_W-2:0]};
      end
   end

   assign tab     = LOGISTIC_TABLE[idx_ff];
   assign lin_rnd = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(HALF_F);
   assign lin     = $signed(lin_rnd[SUM_W:FRACTION_BITS]);

   always_comb begin
      case (cfg.activation_mode)
         MODE_SIGMOID: y_in = $signed(tab);
         MODE_BIPOLAR,
         MODE_TANH:    y_in = $signed({tab[SAMPLE_W-2:0], 1'b0}) - ONE_Q;
         default:      y_in = sat_sample(SAT_W'(lin));
      endcase
   end

   assign factor = (cfg.activation_mode == MODE_SIGMOID) ?
                   (SAMPLE_W + 1)'(ONE_Q) - (SAMPLE_W + 1)'(y_ff) : (SAMPLE_W + 1)'(y_ff);
   assign sq_in  = SQ_W'(y_ff) * SQ_W'(factor);

   assign sq_rnd = (SQ_W + 1)'(sq_ff) + (SQ_W + 1)'(HALF_F);
   assign red    = $signed(sq_rnd[SQ_W:FRACTION_BITS]);

   always_comb begin
      case (cfg.activation_mode)
         MODE_SIGMOID: dv_in = DV_W'(red);
         MODE_BIPOLAR,
         MODE_TANH:    dv_in = DV_W'(ONE_Q) - DV_W'(red);
         default:      dv_in = DV_W'(ONE_Q);
      endcase
   end

   assign gq_in  = GQ_W'(gamma_s) * GQ_W'(dv_ff);
   assign gq_rnd = (GQ_W + 1)'(gq_ff) + (GQ_W + 1)'(HALF_G);
   assign fin    = $signed(gq_rnd[GQ_W:FRACTION_BITS+1]);

   assign deriv_in = (cfg.activation_mode == MODE_BIPOLAR) ?
                     sat_sample(SAT_W'(fin)) : sat_sample(SAT_W'(dv_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.mac) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_weight) begin
         sample_ff <= req_sample;
         first_ff  <= (req_position == '0);
         last_ff   <= last_in;
      end
      if (cmd.scale) begin
         gprod_ff <= gprod_in;
      end
      if (cmd.arg) begin
         arg_ff <= arg_in;
      end
      if (cmd.index) begin
         idx_ff <= idx_in;
      end
      if (cmd.lookup) begin
         y_ff <= y_in;
      end
      if (cmd.square) begin
         sq_ff <= sq_in;
      end
      if (cmd.reduce) begin
         dv_ff <= dv_in;
      end
      if (cmd.gain) begin
         gq_ff <= gq_in;
      end
      if (cmd.load_out) begin
         act_ff   <= y_ff;
         deriv_ff <= deriv_in;
      end
   end

   assign status.last_element = last_ff;
   assign rsp_activation_out  = act_ff;
   assign rsp_derivative_out  = deriv_ff;

endmodule

`default_nettype wire

/* design/neuron_weighted_sum_activation.sv */
// ----------------------------------------------------------------------------
// Neuron weighted sum with activation
// Single fixed point perceptron: weight store, multiply-accumulate over the
// input elements, and linear, sigmoid, bipolar sigmoid or tanh activation with
// its derivative.
// ----------------------------------------------------------------------------
// A weight load transaction leaves the sequencer idle; a data transaction passes
// through a weight store read, then one multiply-accumulate.
// On the last element the result is registered after the scale, argument, index,
// lookup, square, reduce, gain and finish steps, later while an earlier result is
// still stalled, and the next transaction is taken once the sequencer is idle again.
// Synchronous reset clears the sequencer and the running sum and loads the configuration
// defaults; the weight store and the other datapath registers hold no reset value.
`default_nettype none

module neuron_weighted_sum_activation
   import nws_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [POS_W-1:0]             req_position,
   input  logic signed [SAMPLE_W-1:0]   req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_activation_out,
   output logic signed [SAMPLE_W-1:0]   rsp_derivative_out,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   cfg_type         cfg_ff, cfg_in;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ACTIVATION_MODE: cfg_in.activation_mode = csr_write_data[MODE_W-1:0];
            CSR_INPUT_COUNT:     cfg_in.input_count     = csr_write_data[COUNT_W-1:0];
            CSR_BIAS_VALUE:      cfg_in.bias_value      = csr_write_data[SAMPLE_W-1:0];
            CSR_GAMMA_GAIN:      cfg_in.gamma_gain      = csr_write_data[GAMMA_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.activation_mode <= MODE_LINEAR;
         cfg_ff.input_count     <= COUNT_W'(1);
         cfg_ff.bias_value      <= '0;
         cfg_ff.gamma_gain      <= GAMMA_W'(8192);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nws_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .req_position       (req_position),
      .req_sample         (req_sample),
      .status             (status),
      .rsp_activation_out (rsp_activation_out),
      .rsp_derivative_out (rsp_derivative_out)
   );

endmodule

`default_nettype wire
